// ===== sv/eq2q_pkg.sv =====
package eq2q_pkg;

  // CORDIC datapath widths: Q30 sine/cosine, angle in 2^-32 turn units
  localparam int XY_W   = 34;
  localparam int ANG_W  = 34;
  localparam int PROD_W = 2 * XY_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q      = 30;
  localparam int OUT_W  = 16;
  localparam int MAX_STAGES = 32;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  // atan(2^-i) in 2^-32 turn units, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return $signed({{(ANG_W-32){1'b0}}, v});
  endfunction

endpackage

// ===== sv/eq2q_cell.sv =====
module eq2q_cell #(
  parameter int SHIFT = 0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [eq2q_pkg::XY_W-1:0]     x_i,
  input  logic signed [eq2q_pkg::XY_W-1:0]     y_i,
  input  logic signed [eq2q_pkg::ANG_W-1:0]    ang_i,
  output logic signed [eq2q_pkg::XY_W-1:0]     x_o,
  output logic signed [eq2q_pkg::XY_W-1:0]     y_o,
  output logic signed [eq2q_pkg::ANG_W-1:0]    ang_o
);
  import eq2q_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_turn(SHIFT);

  logic signed [XY_W-1:0]  dx, dy;
  logic signed [XY_W-1:0]  x_nxt, y_nxt;
  logic signed [ANG_W-1:0] ang_nxt;

  assign dx = y_i >>> SHIFT;
  assign dy = x_i >>> SHIFT;

  always_comb begin
    if (!ang_i[ANG_W-1]) begin
      x_nxt   = x_i - dx;
      y_nxt   = y_i + dy;
      ang_nxt = ang_i - ATAN;
    end else begin
      x_nxt   = x_i + dx;
      y_nxt   = y_i - dy;
      ang_nxt = ang_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o   <= x_nxt;
      y_o   <= y_nxt;
      ang_o <= ang_nxt;
    end
  end

endmodule

// ===== sv/eq2q_combine.sv =====
module eq2q_combine #(
  parameter int FRAC_BITS = eq2q_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [eq2q_pkg::XY_W-1:0]    cx,
  input  logic signed [eq2q_pkg::XY_W-1:0]    sx,
  input  logic signed [eq2q_pkg::XY_W-1:0]    cy,
  input  logic signed [eq2q_pkg::XY_W-1:0]    sy,
  input  logic signed [eq2q_pkg::XY_W-1:0]    cz,
  input  logic signed [eq2q_pkg::XY_W-1:0]    sz,
  output logic [4*eq2q_pkg::OUT_W-1:0]        quat
);
  import eq2q_pkg::*;

  localparam int SH = 2 * Q - FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (SH - 1);
  localparam logic signed [SUM_W-1:0] ONE  = SUM_W'(1) <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] QHALF = PROD_W'(1) <<< (Q - 1);

  // stage 1: pair products
  logic signed [PROD_W-1:0] p1_r [4];
  logic signed [XY_W-1:0]   cx1_r, sx1_r;
  // stage 2: back to Q30
  logic signed [XY_W-1:0]   p2_r [4];
  logic signed [XY_W-1:0]   cx2_r, sx2_r;
  // stage 3: triple products
  logic signed [PROD_W-1:0] p3_r [8];
  logic signed [SUM_W-1:0]  s [4];
  logic signed [SUM_W-1:0]  r [4];
  logic [4*OUT_W-1:0]       quat_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= cy * cz;
      p1_r[1] <= sy * sz;
      p1_r[2] <= cy * sz;
      p1_r[3] <= sy * cz;
      cx1_r   <= cx;
      sx1_r   <= sx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p2_r[i] <= XY_W'((p1_r[i] + QHALF) >>> Q);
      end
      cx2_r <= cx1_r;
      sx2_r <= sx1_r;
    end
  end

  // p2: 0 cycz, 1 sysz, 2 cysz, 3 sycz
  always_ff @(posedge clk) begin
    if (en) begin
      p3_r[0] <= cx2_r * p2_r[0];
      p3_r[1] <= sx2_r * p2_r[1];
      p3_r[2] <= sx2_r * p2_r[0];
      p3_r[3] <= cx2_r * p2_r[1];
      p3_r[4] <= cx2_r * p2_r[3];
      p3_r[5] <= sx2_r * p2_r[2];
      p3_r[6] <= cx2_r * p2_r[2];
      p3_r[7] <= sx2_r * p2_r[3];
    end
  end

  always_comb begin
    s[0] = SUM_W'(p3_r[0]) + SUM_W'(p3_r[1]);
    s[1] = SUM_W'(p3_r[2]) - SUM_W'(p3_r[3]);
    s[2] = SUM_W'(p3_r[4]) + SUM_W'(p3_r[5]);
    s[3] = SUM_W'(p3_r[6]) - SUM_W'(p3_r[7]);
    for (int i = 0; i < 4; i++) begin
      r[i] = (s[i] + HALF) >>> SH;
      if (r[i] > ONE) begin
        r[i] = ONE;
      end else if (r[i] < -ONE) begin
        r[i] = -ONE;
      end
      quat_nxt[i*OUT_W +: OUT_W] = r[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat <= quat_nxt;
    end
  end

endmodule

// ===== sv/euler_to_quaternion.sv =====
// Channel | Dir | tdata fields (low bit up)                    | tuser/tlast
// in_     | in  | pitch_angle, yaw_angle, roll_angle           | none
// out_    | out | quat_w, quat_x, quat_y, quat_z (16b each)    | none
//
// One beat per cycle in and out while the output is not stalled; the path runs
// through the row of min(CORDIC_STAGES,32) CORDIC cells plus four product/rounding stages.
// Reset (synchronous, active low) clears the stage valid bits only.
// A stall at the output freezes the whole pipeline; in_tready falls only
// while a finished beat waits on out_tready.
module euler_to_quaternion #(
  parameter int ANGLE_BITS    = eq2q_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS     = eq2q_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = eq2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // pitch_angle, yaw_angle, roll_angle; zero fill to bytes
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [4*eq2q_pkg::OUT_W-1:0]           out_tdata
);
  import eq2q_pkg::*;

  localparam int NST = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int LAT = NST + 4;

  logic             en;
  logic [LAT-1:0]   vld_r;
  logic [LAT-1:0]   vld_nxt;

  logic signed [XY_W-1:0]  xs   [3][NST+1];
  logic signed [XY_W-1:0]  ys   [3][NST+1];
  logic signed [ANG_W-1:0] angs [3][NST+1];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // halve each binary angle into 2^-32 turn units (floor)
  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [ANGLE_BITS-1:0] a;
    logic signed [63:0]           h;
    assign a = $signed(in_tdata[k*ANGLE_BITS +: ANGLE_BITS]);
    assign h = (64'(a) <<< 31) >>> ANGLE_BITS;
    assign xs[k][0]   = CORDIC_GAIN;
    assign ys[k][0]   = '0;
    assign angs[k][0] = h[ANG_W-1:0];

    for (genvar i = 0; i < NST; i++) begin : g_cell
      eq2q_cell #(.SHIFT(i)) u_cell (
        .clk   (clk),
        .en    (en),
        .x_i   (xs[k][i]),
        .y_i   (ys[k][i]),
        .ang_i (angs[k][i]),
        .x_o   (xs[k][i+1]),
        .y_o   (ys[k][i+1]),
        .ang_o (angs[k][i+1])
      );
    end
  end

  eq2q_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
    .clk  (clk),
    .en   (en),
    .cx   (xs[0][NST]),
    .sx   (ys[0][NST]),
    .cy   (xs[1][NST]),
    .sy   (ys[1][NST]),
    .cz   (xs[2][NST]),
    .sz   (ys[2][NST]),
    .quat (out_tdata)
  );

  assign vld_nxt = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat did not enter pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  a_w_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (FRAC_BITS == 14) |->
      ($signed(out_tdata[15:0]) <= 16'sd16384) &&
      ($signed(out_tdata[15:0]) >= -16'sd16384))
    else $error("quat_w outside clamp range");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import eq2q_pkg::*;

  localparam int AB      = ANGLE_BITS_DEF;
  localparam int FB      = FRAC_BITS_DEF;
  localparam int STAGES  = CORDIC_STAGES_DEF;
  localparam int IN_W    = ((3*AB+7)/8)*8;
  localparam int LATENCY = ((STAGES < MAX_STAGES) ? STAGES : MAX_STAGES) + 4;
  localparam int N_RAND  = 1330;
  localparam int LIMIT   = 400000;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  typedef struct {
    logic [AB-1:0] pitch, yaw, roll;
    logic          known;   // expected value typed into the table
    quat_t         q;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [4*OUT_W-1:0] out_tdata;

  quat_t quat_expected[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    quiet_tail = 1'b0;   // no idling near the end
  bit    sending_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_to_quaternion u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),      // pitch, yaw, roll
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)      // w, x, y, z
  );

  // ---- predictor -----------------------------------------------------------
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;   // arithmetic shift on signed longint is floor
  endfunction

  // half angle in 2^-32 turn units, floor division by two
  function automatic longint half_turns(logic [AB-1:0] raw);
    longint a, t;
    a = longint'($signed(raw));
    t = a * (longint'(1) << (32 - AB));
    return (t - (t & 1)) / 2;
  endfunction

  function automatic void cordic_sincos(longint ang, output longint c, output longint s);
    longint cx, sy, dx, dy;
    cx = 652032874;
    sy = 0;
    for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
      dx = shr_floor(sy, i);
      dy = shr_floor(cx, i);
      if (ang >= 0) begin
        cx -= dx; sy += dy; ang -= longint'(atan_turn(i));
      end else begin
        cx += dx; sy -= dy; ang += longint'(atan_turn(i));
      end
    end
    c = cx;
    s = sy;
  endfunction

  function automatic longint mul_round_q30(longint a, longint b);
    return shr_floor(a * b + (longint'(1) << 29), 30);
  endfunction

  function automatic logic [15:0] round_clamp(longint q60);
    longint one, r;
    one = longint'(1) << FB;
    r = shr_floor(q60 + (longint'(1) << (59 - FB)), 60 - FB);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic quat_t euler_to_quat(logic [AB-1:0] p, logic [AB-1:0] yw,
                                          logic [AB-1:0] rl);
    longint cx, sx, cy, sy, cz, sz, cycz, sysz, cysz, sycz;
    quat_t q;
    cordic_sincos(half_turns(p), cx, sx);
    cordic_sincos(half_turns(yw), cy, sy);
    cordic_sincos(half_turns(rl), cz, sz);
    cycz = mul_round_q30(cy, cz);
    sysz = mul_round_q30(sy, sz);
    cysz = mul_round_q30(cy, sz);
    sycz = mul_round_q30(sy, cz);
    q.w = round_clamp(cx * cycz + sx * sysz);
    q.x = round_clamp(sx * cycz - cx * sysz);
    q.y = round_clamp(cx * sycz + sx * cysz);
    q.z = round_clamp(cx * cysz - sx * sycz);
    return q;
  endfunction

  // ---- sender --------------------------------------------------------------
  task automatic send_angles(logic [AB-1:0] p, logic [AB-1:0] yw, logic [AB-1:0] rl,
                             quat_t q);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({rl, yw, p});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quat_expected.push_back(q);
  endtask

  function automatic logic [AB-1:0] random_angle();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(AB-1){1'b0}}};
      1: return {1'b0, {(AB-1){1'b1}}};
      2: return AB'($urandom_range(0, 15)) - AB'(8);   // near zero
      3: return AB'(16'h4000 + $urandom_range(0, 6) - 3);  // near pi/2
      default: return AB'($urandom);
    endcase
  endfunction

  // Directed rows; expectations typed in only where obvious
  localparam logic [AB-1:0] A_ZERO = '0;
  localparam logic [AB-1:0] A_MIN  = 16'h8000;
  localparam logic [AB-1:0] A_MAX  = 16'h7FFF;
  localparam logic [AB-1:0] A_HALF = 16'h4000;   // pi/2
  localparam logic [AB-1:0] A_NEGH = 16'hC000;   // -pi/2

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [AB-1:0] p, logic [AB-1:0] yw,
                                    logic [AB-1:0] rl);
    stim_row_t r;
    r.pitch = p; r.yaw = yw; r.roll = rl; r.known = 1'b0; r.q = '0;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    quat_t q;
    // zero rotation gives identity
    r = row(A_ZERO, A_ZERO, A_ZERO); r.known = 1'b1;
    r.q = '{z: 16'sd0, y: 16'sd0, x: 16'sd0, w: 16'sd16384};
    directed.push_back(r);
    directed.push_back(row(A_MIN, A_ZERO, A_ZERO));
    directed.push_back(row(A_ZERO, A_MIN, A_ZERO));
    directed.push_back(row(A_ZERO, A_ZERO, A_MIN));
    directed.push_back(row(A_MAX, A_ZERO, A_ZERO));
    directed.push_back(row(A_ZERO, A_MAX, A_ZERO));
    directed.push_back(row(A_ZERO, A_ZERO, A_MAX));
    directed.push_back(row(A_MIN, A_MIN, A_MIN));
    directed.push_back(row(A_MAX, A_MAX, A_MAX));
    directed.push_back(row(A_HALF, A_HALF, A_HALF));
    directed.push_back(row(A_NEGH, A_NEGH, A_NEGH));
    directed.push_back(row(A_HALF, A_ZERO, A_NEGH));
    directed.push_back(row(16'h0001, 16'hFFFF, 16'h0001));
    directed.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(row(16'h5555, 16'hAAAA, 16'h3333));
    directed.push_back(row(16'hAAAA, 16'h5555, 16'hCCCC));
    directed.push_back(row(A_MAX, A_MIN, A_HALF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      q = euler_to_quat(directed[i].pitch, directed[i].yaw, directed[i].roll);
      if (directed[i].known) q = directed[i].q;
      send_angles(directed[i].pitch, directed[i].yaw, directed[i].roll, q);
    end

    for (int n = 0; n < N_RAND; n++) begin
      logic [AB-1:0] p, yw, rl;
      // hold off once until the pipe drains
      if (n == N_RAND / 3) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (quat_expected.size() != 0) @(posedge clk);
      end
      if (n == N_RAND - 150) quiet_tail = 1'b1;
      p = random_angle(); yw = random_angle(); rl = random_angle();
      send_angles(p, yw, rl, euler_to_quat(p, yw, rl));
    end
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // ---- receiver ------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = quat_t'(out_tdata);
      if (quat_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", out_tdata);
      end else begin
        want = quat_expected.pop_front();
        if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("quat mismatch: want w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  // ---- end of run ----------------------------------------------------------
  initial begin
    wait (sending_done);
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && quat_expected.size() == 0) begin
      $display("PASS euler_to_quaternion");
    end else begin
      $display("FAIL euler_to_quaternion");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL euler_to_quaternion");
      $finish;
    end
  end

endmodule
